### rtl/core/lc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear convolution package
// Shared constants, request codes and the command flag group that passes
// from the front end to the execution engine.
// ----------------------------------------------------------------------------
package lc_pkg;

  // Default configuration of the convolution engine.
  localparam int LC_MAX_TAPS    = 32;
  localparam int LC_SAMPLE_BITS = 16;

  // Fixed port widths.
  localparam int IN_SAMPLE_W = 16;
  localparam int CONV_W      = 40;

  // Depth of the queues between the parts of the block.
  localparam int QUEUE_DEPTH = 2;

  // Request type codes.
  localparam logic REQ_IMPULSE = 1'b0;
  localparam logic REQ_SIGNAL  = 1'b1;

  // Flags that travel with each command. A command with is_signal low is a
  // tap store write.
  typedef struct packed {
    logic is_signal;
    logic clear_line;
    logic last;
    logic overflow;
  } cmd_flags_t;

endpackage

### rtl/core/linear_convolution.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear convolution
// Streaming full linear convolution built as a direct-form FIR filter with a
// single shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Usage: both channels behave as queues. A transaction is written with
// in_push while in_full is low. Impulse samples (in_req_type low) load the
// tap store in order, and the one with in_last high fixes the tap count M.
// Signal samples (in_req_type high) each yield one result; the signal sample
// with in_last high yields M results, the tail being computed with zeros
// shifted in, and the final one carries out_final_output.
// Results are read with out_pop while out_empty is low.
//
// Timing: a front end classifies each transaction and queues a command; the
// back end runs the multiply-accumulate over the taps, one tap per cycle
// through the registered memory reads and a registered multiplier. Each
// result is then pushed into the output queue, and a closing sample runs one
// pass per result. The engine takes a new command only from its idle state,
// after every result of a signal sample has been pushed.
//
// Reset: rst_n clears the queues and the tap and signal state; the tap count
// is one with a zero tap. No clearing pass is needed. When the receiver
// stalls, finished results wait in the output queue, the engine then holds,
// and once the command queue fills in_full rises.
// ----------------------------------------------------------------------------
module linear_convolution #(
  parameter int MAX_TAPS    = lc_pkg::LC_MAX_TAPS,
  parameter int SAMPLE_BITS = lc_pkg::LC_SAMPLE_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_push,
  output logic                                  in_full,
  input  logic                                  in_req_type,
  input  logic signed [lc_pkg::IN_SAMPLE_W-1:0] in_sample,
  input  logic                                  in_last,
  output logic                                  out_empty,
  input  logic                                  out_pop,
  output logic signed [lc_pkg::CONV_W-1:0]      out_conv_value,
  output logic                                  out_final_output,
  output logic                                  out_tap_overflow
);
  import lc_pkg::*;

  localparam int TIW   = $clog2(MAX_TAPS);
  localparam int TCW   = $clog2(MAX_TAPS + 1);
  localparam int FL_W  = $bits(cmd_flags_t);
  localparam int CMD_W = FL_W + SAMPLE_BITS + TIW + TCW;
  localparam int RES_W = CONV_W + 2;

  // Front end to command queue.
  logic                   f_push;
  cmd_flags_t             f_flags;
  logic [SAMPLE_BITS-1:0] f_sample;
  logic [TIW-1:0]         f_addr;
  logic [TCW-1:0]         f_taps;
  logic [CMD_W-1:0]       cmd_din;
  logic [CMD_W-1:0]       cmd_dout;
  logic                   cmd_full;
  logic                   cmd_empty;

  // Command queue to engine.
  logic                   b_pop;
  cmd_flags_t             b_flags;
  logic [SAMPLE_BITS-1:0] b_sample;
  logic [TIW-1:0]         b_addr;
  logic [TCW-1:0]         b_taps;

  // Engine to result queue.
  logic                   res_push;
  logic                   res_full;
  logic [CONV_W-1:0]      res_value;
  logic                   res_final;
  logic                   res_ovf;
  logic [RES_W-1:0]       res_din;
  logic [RES_W-1:0]       res_dout;

  assign in_full = cmd_full;

  lc_front #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_req_type (in_req_type),
    .in_sample   (in_sample),
    .in_last     (in_last),
    .cmd_full    (cmd_full),
    .cmd_push    (f_push),
    .cmd_flags   (f_flags),
    .cmd_sample  (f_sample),
    .cmd_addr    (f_addr),
    .cmd_taps    (f_taps)
  );

  assign cmd_din = {f_flags, f_sample, f_addr, f_taps};

  lc_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .din   (cmd_din),
    .full  (cmd_full),
    .pop   (b_pop),
    .dout  (cmd_dout),
    .empty (cmd_empty)
  );

  assign {b_flags, b_sample, b_addr, b_taps} = cmd_dout;

  lc_back #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_avail  (!cmd_empty),
    .cmd_pop    (b_pop),
    .cmd_flags  (b_flags),
    .cmd_sample (b_sample),
    .cmd_addr   (b_addr),
    .cmd_taps   (b_taps),
    .res_full   (res_full),
    .res_push   (res_push),
    .res_value  (res_value),
    .res_final  (res_final),
    .res_ovf    (res_ovf)
  );

  assign res_din = {res_value, res_final, res_ovf};

  lc_fifo #(
    .WIDTH (RES_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_din),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (res_dout),
    .empty (out_empty)
  );

  assign {out_conv_value, out_final_output, out_tap_overflow} = res_dout;

endmodule

### rtl/core/lc_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Small synchronous queue
// A register-based first-in first-out buffer used between the parts.
// ----------------------------------------------------------------------------
module lc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = lc_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);
  import lc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

### rtl/core/lc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear convolution front end
// Accepts transactions, tracks the tap loading state and turns each item into
// a tap write or a signal command for the engine, or drops an excess impulse.
// ----------------------------------------------------------------------------
module lc_front #(
  parameter int MAX_TAPS    = lc_pkg::LC_MAX_TAPS,
  parameter int SAMPLE_BITS = lc_pkg::LC_SAMPLE_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  input  logic                               in_req_type,
  input  logic signed [lc_pkg::IN_SAMPLE_W-1:0] in_sample,
  input  logic                               in_last,
  input  logic                               cmd_full,
  output logic                               cmd_push,
  output lc_pkg::cmd_flags_t                 cmd_flags,
  output logic [SAMPLE_BITS-1:0]             cmd_sample,
  output logic [$clog2(MAX_TAPS)-1:0]        cmd_addr,
  output logic [$clog2(MAX_TAPS+1)-1:0]      cmd_taps
);
  import lc_pkg::*;

  localparam int TIW   = $clog2(MAX_TAPS);
  localparam int TCW   = $clog2(MAX_TAPS + 1);
  localparam int RAW_W = (SAMPLE_BITS > IN_SAMPLE_W) ? SAMPLE_BITS : IN_SAMPLE_W;

  logic [TCW-1:0]   wr_pos_r, wr_pos_nxt;
  logic [TCW-1:0]   taps_r, taps_nxt;
  logic             imp_pend_r, imp_pend_nxt;
  logic             sig_pend_r, sig_pend_nxt;
  logic             ovf_r, ovf_nxt;
  logic             accept;
  logic [TCW-1:0]   base_pos;
  logic             base_ovf;
  logic             room;
  logic [RAW_W-1:0] raw;

  // Only the low SAMPLE_BITS bits of the port carry the sample.
  assign raw        = RAW_W'($unsigned(in_sample));
  assign cmd_sample = raw[SAMPLE_BITS-1:0];
  assign accept     = in_push && !cmd_full;

  // A new impulse load restarts at position zero with a clean overflow flag.
  assign base_pos = imp_pend_r ? '0 : wr_pos_r;
  assign base_ovf = imp_pend_r ? 1'b0 : ovf_r;
  assign room     = (base_pos < TCW'(MAX_TAPS));
  assign cmd_addr = base_pos[TIW-1:0];
  assign cmd_taps = taps_r;

  always_comb begin
    wr_pos_nxt         = wr_pos_r;
    taps_nxt           = taps_r;
    imp_pend_nxt       = imp_pend_r;
    sig_pend_nxt       = sig_pend_r;
    ovf_nxt            = ovf_r;
    cmd_push           = 1'b0;
    cmd_flags          = '0;
    cmd_flags.last     = in_last;
    cmd_flags.overflow = ovf_r;
    if (accept) begin
      if (in_req_type == REQ_IMPULSE) begin
        ovf_nxt      = base_ovf || !room;
        wr_pos_nxt   = room ? base_pos + 1'b1 : base_pos;
        imp_pend_nxt = in_last;
        if (in_last) begin
          taps_nxt = wr_pos_nxt;
        end
        cmd_push = room;
      end else begin
        sig_pend_nxt         = in_last;
        cmd_push             = 1'b1;
        cmd_flags.is_signal  = 1'b1;
        cmd_flags.clear_line = sig_pend_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pos_r   <= '0;
      taps_r     <= TCW'(1);
      imp_pend_r <= 1'b1;
      sig_pend_r <= 1'b1;
      ovf_r      <= 1'b0;
    end else begin
      wr_pos_r   <= wr_pos_nxt;
      taps_r     <= taps_nxt;
      imp_pend_r <= imp_pend_nxt;
      sig_pend_r <= sig_pend_nxt;
      ovf_r      <= ovf_nxt;
    end
  end

endmodule

### rtl/core/lc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear convolution execution engine
// Holds the tap store and the circular delay line, and runs one shared
// multiply-accumulate over the taps for every result.
// ----------------------------------------------------------------------------
module lc_back #(
  parameter int MAX_TAPS    = lc_pkg::LC_MAX_TAPS,
  parameter int SAMPLE_BITS = lc_pkg::LC_SAMPLE_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cmd_avail,
  output logic                            cmd_pop,
  input  lc_pkg::cmd_flags_t              cmd_flags,
  input  logic [SAMPLE_BITS-1:0]          cmd_sample,
  input  logic [$clog2(MAX_TAPS)-1:0]     cmd_addr,
  input  logic [$clog2(MAX_TAPS+1)-1:0]   cmd_taps,
  input  logic                            res_full,
  output logic                            res_push,
  output logic [lc_pkg::CONV_W-1:0]       res_value,
  output logic                            res_final,
  output logic                            res_ovf
);
  import lc_pkg::*;

  localparam int TIW = $clog2(MAX_TAPS);
  localparam int TCW = $clog2(MAX_TAPS + 1);
  localparam int PW  = 2 * SAMPLE_BITS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MAC  = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [SAMPLE_BITS-1:0] tap_mem [MAX_TAPS];
  logic [SAMPLE_BITS-1:0] dly_mem [2**TIW];

  logic [1:0]              state_r, state_nxt;
  logic [TIW-1:0]          head_r, head_nxt;
  logic [TCW-1:0]          fill_r, fill_nxt;
  logic [TCW-1:0]          taps_r, taps_nxt;
  logic [TCW-1:0]          left_r, left_nxt;
  logic [TCW-1:0]          iss_r, iss_nxt;
  logic                    last_r, last_nxt;
  logic                    ovf_r, ovf_nxt;
  logic                    tap_written_r, tap_written_nxt;
  logic                    v1_r, v2_r, ok1_r;
  logic [SAMPLE_BITS-1:0]  tap_q_r, dly_q_r;
  logic signed [SAMPLE_BITS-1:0] tap_val, dly_val;
  logic signed [PW-1:0]    prod_r;
  logic [CONV_W-1:0]       acc_r;
  logic                    acc_clr;
  logic                    issue;
  logic                    mac_done;
  logic                    tap_we;
  logic                    dly_we;
  logic [SAMPLE_BITS-1:0]  dly_wd;
  logic [TCW-1:0]          fill_base;

  assign issue    = (state_r == S_MAC) && (iss_r < taps_r);
  assign mac_done = (state_r == S_MAC) && !issue && !v1_r && !v2_r;

  // Entries past the fill level read as zero, so the line needs no clearing.
  // Only tap zero can be read before any tap load, and it reads as zero until then.
  assign tap_val = tap_written_r ? $signed(tap_q_r) : '0;
  assign dly_val = ok1_r ? $signed(dly_q_r) : '0;

  assign res_value = acc_r;
  assign res_final = last_r && (left_r == TCW'(1));
  assign res_ovf   = ovf_r;

  always_comb begin
    state_nxt       = state_r;
    head_nxt        = head_r;
    fill_nxt        = fill_r;
    taps_nxt        = taps_r;
    left_nxt        = left_r;
    iss_nxt         = issue ? iss_r + 1'b1 : iss_r;
    last_nxt        = last_r;
    ovf_nxt         = ovf_r;
    tap_written_nxt = tap_written_r;
    cmd_pop         = 1'b0;
    res_push        = 1'b0;
    tap_we          = 1'b0;
    dly_we          = 1'b0;
    dly_wd          = cmd_sample;
    acc_clr         = 1'b0;
    fill_base       = fill_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_avail) begin
          cmd_pop = 1'b1;
          if (!cmd_flags.is_signal) begin
            tap_we          = 1'b1;
            tap_written_nxt = 1'b1;
          end else begin
            fill_base = cmd_flags.clear_line ? '0 : fill_r;
            dly_we    = 1'b1;
            taps_nxt  = cmd_taps;
            last_nxt  = cmd_flags.last;
            ovf_nxt   = cmd_flags.overflow;
            left_nxt  = (cmd_flags.last && (cmd_taps != '0)) ? cmd_taps : TCW'(1);
            iss_nxt   = '0;
            acc_clr   = 1'b1;
            state_nxt = S_MAC;
          end
        end
      end
      S_MAC: begin
        if (mac_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!res_full) begin
          res_push = 1'b1;
          if (left_r != TCW'(1)) begin
            // Flush the tail: shift a zero in and run another pass.
            dly_we    = 1'b1;
            dly_wd    = '0;
            left_nxt  = left_r - 1'b1;
            iss_nxt   = '0;
            acc_clr   = 1'b1;
            state_nxt = S_MAC;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (dly_we) begin
      head_nxt = head_r + 1'b1;
      fill_nxt = (fill_base < TCW'(MAX_TAPS)) ? fill_base + 1'b1 : fill_base;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      head_r        <= '0;
      fill_r        <= '0;
      taps_r        <= '0;
      left_r        <= '0;
      iss_r         <= '0;
      last_r        <= 1'b0;
      ovf_r         <= 1'b0;
      tap_written_r <= 1'b0;
      v1_r          <= 1'b0;
      v2_r          <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      head_r        <= head_nxt;
      fill_r        <= fill_nxt;
      taps_r        <= taps_nxt;
      left_r        <= left_nxt;
      iss_r         <= iss_nxt;
      last_r        <= last_nxt;
      ovf_r         <= ovf_nxt;
      tap_written_r <= tap_written_nxt;
      v1_r          <= issue;
      v2_r          <= v1_r;
    end
  end

  // Tap store: written by load commands, read once per tap during a pass.
  always_ff @(posedge clk) begin
    if (tap_we) begin
      tap_mem[cmd_addr] <= cmd_sample;
    end
    if (issue) begin
      tap_q_r <= tap_mem[iss_r[TIW-1:0]];
    end
  end

  // Delay line: the newest sample sits at head, older ones below it.
  always_ff @(posedge clk) begin
    if (dly_we) begin
      dly_mem[head_r + 1'b1] <= dly_wd;
    end
    if (issue) begin
      dly_q_r <= dly_mem[head_r - iss_r[TIW-1:0]];
      ok1_r   <= (iss_r < fill_r);
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r) begin
      prod_r <= tap_val * dly_val;
    end
    if (acc_clr) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= acc_r + CONV_W'(prod_r);
    end
  end

endmodule

### sim/conv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Convolution checker
// Watches both queue interfaces of the linear convolution block, predicts the
// results of every accepted transaction and compares them in order.
// ----------------------------------------------------------------------------
module conv_checker #(
  parameter int MAX_TAPS = lc_pkg::LC_MAX_TAPS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_push,
  input  logic                                  in_full,
  input  logic                                  in_req_type,
  input  logic signed [lc_pkg::IN_SAMPLE_W-1:0] in_sample,
  input  logic                                  in_last,
  input  logic                                  out_empty,
  input  logic                                  out_pop,
  input  logic signed [lc_pkg::CONV_W-1:0]      out_conv_value,
  input  logic                                  out_final_output,
  input  logic                                  out_tap_overflow,
  output int                                    fail_count,
  output int                                    pending
);
  import lc_pkg::*;

  typedef struct packed {
    logic [CONV_W-1:0] value;
    logic              final_output;
    logic              tap_overflow;
  } conv_result_t;

  conv_result_t expected_outputs[$];

  // Shadow of the filter state.
  logic signed [IN_SAMPLE_W-1:0] taps [MAX_TAPS];
  logic signed [IN_SAMPLE_W-1:0] line [MAX_TAPS];
  int unsigned tap_cnt = 1;
  int unsigned wr_pos = 0;
  bit impulse_restart = 1'b1;
  bit signal_restart = 1'b1;
  bit taps_dropped = 1'b0;
  int results_seen = 0;

  initial begin
    fail_count = 0;
    pending = 0;
    for (int i = 0; i < MAX_TAPS; i++) begin
      taps[i] = '0;
      line[i] = '0;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("conv_checker: %s at result %0d: got %h, expected %h", what,
             results_seen, got, want);
    fail_count++;
  endtask

  function automatic void shift_line(input logic signed [IN_SAMPLE_W-1:0] x);
    for (int i = MAX_TAPS - 1; i > 0; i--) line[i] = line[i-1];
    line[0] = x;
  endfunction

  function automatic conv_result_t mac_result(input logic fin);
    longint acc;
    int unsigned n;
    conv_result_t r;
    acc = 0;
    n = (tap_cnt > MAX_TAPS) ? MAX_TAPS : tap_cnt;
    for (int k = 0; k < n; k++) acc += longint'(taps[k]) * longint'(line[k]);
    r.value = acc[CONV_W-1:0];
    r.final_output = fin;
    r.tap_overflow = taps_dropped;
    return r;
  endfunction

  // Applies one accepted transaction to the shadow state and queues the
  // results it must cause.
  task automatic convolve_sample(input logic req, input logic signed [IN_SAMPLE_W-1:0] x,
                                 input logic last_flag);
    int unsigned total;
    if (req == REQ_IMPULSE) begin
      if (impulse_restart) begin
        wr_pos = 0;
        taps_dropped = 1'b0;
        impulse_restart = 1'b0;
      end
      if (wr_pos < MAX_TAPS) begin
        taps[wr_pos] = x;
        wr_pos++;
      end else begin
        taps_dropped = 1'b1;
      end
      if (last_flag) begin
        tap_cnt = wr_pos;
        impulse_restart = 1'b1;
      end
    end else begin
      if (signal_restart) begin
        for (int i = 0; i < MAX_TAPS; i++) line[i] = '0;
        signal_restart = 1'b0;
      end
      shift_line(x);
      if (!last_flag) begin
        expected_outputs.push_back(mac_result(1'b0));
      end else begin
        total = (tap_cnt > MAX_TAPS) ? MAX_TAPS : tap_cnt;
        if (total == 0) total = 1;
        for (int r = 0; r < total; r++) begin
          if (r > 0) shift_line('0);
          expected_outputs.push_back(mac_result(r + 1 == total));
        end
        signal_restart = 1'b1;
      end
    end
  endtask

  always @(posedge clk) begin
    conv_result_t want;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        results_seen++;
        if (expected_outputs.size() == 0) begin
          report_mismatch("unexpected result", 64'($unsigned(out_conv_value)), '0);
        end else begin
          want = expected_outputs.pop_front();
          if (out_conv_value !== want.value)
            report_mismatch("conv_value", 64'($unsigned(out_conv_value)),
                            64'(want.value));
          if (out_final_output !== want.final_output)
            report_mismatch("final_output", 64'(out_final_output),
                            64'(want.final_output));
          if (out_tap_overflow !== want.tap_overflow)
            report_mismatch("tap_overflow", 64'(out_tap_overflow),
                            64'(want.tap_overflow));
        end
      end
      if (in_push && !in_full) convolve_sample(in_req_type, in_sample, in_last);
    end
    pending <= expected_outputs.size();
  end

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear convolution testbench
// Drives impulse and signal transactions into the convolution block with
// bursty timing, drains results under a varying stall pattern, and leaves
// prediction and comparison to the checker instantiated beside the block.
// ----------------------------------------------------------------------------
module testbench;
  import lc_pkg::*;

  // Receiver behavior, switched at random intervals so that stalls land on
  // every phase of the engine's work.
  typedef enum logic [1:0] {
    DRAIN_FREE,
    DRAIN_HALF,
    DRAIN_SPARSE,
    DRAIN_HOLD
  } drain_mode_t;

  localparam int ITEM_TARGET = 370;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_push = 1'b0;
  logic                         in_full;
  logic                         in_req_type = REQ_IMPULSE;
  logic signed [IN_SAMPLE_W-1:0] in_sample = '0;
  logic                         in_last = 1'b0;
  logic                         out_empty;
  logic                         out_pop = 1'b0;
  logic signed [CONV_W-1:0]     out_conv_value;
  logic                         out_final_output;
  logic                         out_tap_overflow;

  int fail_count;
  int pending;
  int items_sent = 0;
  int burst_left = 0;

  drain_mode_t drain_mode = DRAIN_FREE;
  int          drain_left = 0;

  always #2 clk = ~clk;

  linear_convolution DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_req_type      (in_req_type),
    .in_sample        (in_sample),
    .in_last          (in_last),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_conv_value   (out_conv_value),
    .out_final_output (out_final_output),
    .out_tap_overflow (out_tap_overflow)
  );

  conv_checker conv_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_req_type      (in_req_type),
    .in_sample        (in_sample),
    .in_last          (in_last),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_conv_value   (out_conv_value),
    .out_final_output (out_final_output),
    .out_tap_overflow (out_tap_overflow),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  // The receiver picks a drain mode, holds it for a random stretch, then
  // picks again. The hold mode stops popping entirely so that the output
  // queue fills, the engine stalls and in_full eventually rises.
  always @(posedge clk) begin
    if (drain_left == 0) begin
      drain_mode <= drain_mode_t'($urandom_range(0, 3));
      drain_left <= $urandom_range(16, 200);
    end else begin
      drain_left <= drain_left - 1;
    end
    case (drain_mode)
      DRAIN_FREE:   out_pop <= 1'b1;
      DRAIN_HALF:   out_pop <= 1'($urandom_range(0, 1));
      DRAIN_SPARSE: out_pop <= ($urandom_range(0, 7) == 0);
      default:      out_pop <= 1'b0;
    endcase
  end

  // Sends one transaction and returns in the time step of its acceptance.
  // The sender works in bursts: while a burst lasts, the next call follows
  // in the same step with push kept high; at the end of a burst push drops
  // for a random gap and a new burst length is drawn. Long bursts give
  // stretches without any idling.
  task automatic push_item(input logic req, input logic signed [IN_SAMPLE_W-1:0] x,
                           input logic last_flag);
    in_push <= 1'b1;
    in_req_type <= req;
    in_sample <= x;
    in_last <= last_flag;
    @(posedge clk);
    while (in_full !== 1'b0) @(posedge clk);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 8);
    end
  endtask

  // Sample values lean on the two extremes and on small values around zero,
  // while the plain random draw makes every bit of the field toggle.
  function automatic logic signed [IN_SAMPLE_W-1:0] pick_sample();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 16'h7FFF;
    if (sel == 1) return 16'h8000;
    if (sel == 2) return $signed(16'($urandom_range(0, 8))) - 16'sd4;
    return IN_SAMPLE_W'($urandom);
  endfunction

  // Loads n impulse samples. A load may be left open on purpose, in which
  // case the next load continues at the current write position. Now and then
  // a signal sample is slipped into the middle of the load, which makes the
  // engine run over a tap store that is partly overwritten.
  task automatic load_taps(input int n, input bit commit);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0)
        push_item(REQ_SIGNAL, pick_sample(), $urandom_range(0, 3) == 0);
      push_item(REQ_IMPULSE, pick_sample(), commit && (i == n - 1));
    end
  endtask

  // Plays one signal of len samples. Without a closing sample, the next
  // signal keeps the same delay line content.
  task automatic play_signal(input int len, input bit close);
    for (int i = 0; i < len; i++)
      push_item(REQ_SIGNAL, pick_sample(), close && (i == len - 1));
  endtask

  initial begin
    int pick;
    int n_taps;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Signal right after reset: the tap store holds a single zero tap, so a
    // closing sample yields one result of zero, marked final.
    push_item(REQ_SIGNAL, 16'h7FFF, 1'b0);
    push_item(REQ_SIGNAL, 16'h8000, 1'b1);

    // Single tap at the negative extreme against both extremes of the signal.
    push_item(REQ_IMPULSE, 16'h8000, 1'b1);
    push_item(REQ_SIGNAL, 16'h8000, 1'b0);
    push_item(REQ_SIGNAL, 16'h7FFF, 1'b0);
    push_item(REQ_SIGNAL, 16'hFFFF, 1'b1);

    // Three taps; the closing sample flushes two tail results.
    push_item(REQ_IMPULSE, 16'h7FFF, 1'b0);
    push_item(REQ_IMPULSE, 16'h8000, 1'b0);
    push_item(REQ_IMPULSE, 16'h0001, 1'b1);
    push_item(REQ_SIGNAL, 16'h8000, 1'b0);
    push_item(REQ_SIGNAL, 16'h8000, 1'b0);
    push_item(REQ_SIGNAL, 16'h7FFF, 1'b0);
    push_item(REQ_SIGNAL, 16'h0000, 1'b1);

    // A new tap load is cut into by a signal: the engine still uses the old
    // tap count over the partly overwritten store.
    push_item(REQ_IMPULSE, 16'h7FFF, 1'b0);
    push_item(REQ_IMPULSE, 16'hFFFE, 1'b0);
    push_item(REQ_SIGNAL, 16'h3039, 1'b1);
    push_item(REQ_IMPULSE, 16'h0007, 1'b1);

    // A signal whose middle sample carries no mark, then a closing sample.
    push_item(REQ_SIGNAL, 16'h0001, 1'b0);
    push_item(REQ_SIGNAL, 16'hFFFF, 1'b0);
    push_item(REQ_SIGNAL, 16'h5555, 1'b1);

    // Random rounds: a tap load, then a few signals. Most loads are short to
    // keep the closing flushes cheap; some fill the store exactly and some
    // run past it so that taps are dropped and the overflow flag is set.
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 9);
      if (pick <= 5)      n_taps = $urandom_range(1, 6);
      else if (pick == 6) n_taps = $urandom_range(7, 31);
      else if (pick == 7) n_taps = LC_MAX_TAPS;
      else if (pick == 8) n_taps = $urandom_range(LC_MAX_TAPS + 1, LC_MAX_TAPS + 5);
      else                n_taps = 1;
      load_taps(n_taps, $urandom_range(0, 9) != 0);
      repeat ($urandom_range(1, 3))
        play_signal($urandom_range(1, 10), $urandom_range(0, 9) != 0);
    end

    // Close any signal left open, so the last results carry the final mark.
    push_item(REQ_SIGNAL, pick_sample(), 1'b1);
    in_push <= 1'b0;

    // One edge first so that the count of waiting results includes the last
    // transaction, then drain, then let a few engine passes go by to catch
    // any stray result.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest legal run of this stimulus.
  initial begin
    #20000000;
    $display("tb: failure");
    $finish;
  end

endmodule

### linear_convolution.f
rtl/core/lc_pkg.sv
rtl/core/lc_fifo.sv
rtl/core/lc_front.sv
rtl/core/lc_back.sv
rtl/core/linear_convolution.sv
sim/conv_checker.sv
sim/testbench.sv
